### rtl/core/fdit_pkg.sv
// Package with the constants, types and helper functions of the radix-2 DIT FFT.
`timescale 1ns / 1ps
package fdit_pkg;
  localparam int LOG_MAX = 10;
  localparam int MAX_POINTS = 1 << LOG_MAX;
  localparam int SAMPLE_BITS = 16;
  localparam int TW_BITS = 16;
  localparam int DATA_BITS = 27;
  localparam int AW = LOG_MAX;
  localparam int CW = LOG_MAX + 1;
  localparam int LW = $clog2(LOG_MAX + 1);
  localparam int TW_DEPTH = MAX_POINTS / 2;
  localparam int TA = $clog2(TW_DEPTH);
  localparam int PHASE_BITS = 16;
  localparam int PROD_BITS = DATA_BITS + TW_BITS;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  // Rounded-up reciprocals of the series divisors; exact for dividends below 2^30.
  localparam int RCP_SH = 38;
  localparam longint unsigned RCP_COS [6] = '{
    ((64'd1 << RCP_SH) + 64'd1) / 64'd2,
    ((64'd1 << RCP_SH) + 64'd11) / 64'd12,
    ((64'd1 << RCP_SH) + 64'd29) / 64'd30,
    ((64'd1 << RCP_SH) + 64'd55) / 64'd56,
    ((64'd1 << RCP_SH) + 64'd89) / 64'd90,
    ((64'd1 << RCP_SH) + 64'd131) / 64'd132
  };
  localparam longint unsigned RCP_SIN [6] = '{
    ((64'd1 << RCP_SH) + 64'd5) / 64'd6,
    ((64'd1 << RCP_SH) + 64'd19) / 64'd20,
    ((64'd1 << RCP_SH) + 64'd41) / 64'd42,
    ((64'd1 << RCP_SH) + 64'd71) / 64'd72,
    ((64'd1 << RCP_SH) + 64'd109) / 64'd110,
    ((64'd1 << RCP_SH) + 64'd155) / 64'd156
  };

  typedef logic signed [DATA_BITS-1:0] data_t;
  typedef logic signed [TW_BITS-1:0] tw_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_PAD, ST_REV_RD, ST_REV_W1, ST_REV_W2,
    ST_BF_RD, ST_BF_MUL, ST_BF_SUM, ST_BF_WP, ST_BF_WQ
  } fdit_state_t;

  function automatic longint round_q(longint v);
    longint s;
    s = 30 - (TW_BITS - 1);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic [2*TW_BITS-1:0] tw_calc(int t);
    longint unsigned p, quad, r, x, x2, ct, st, cs, ss;
    longint c, s, cr, sr, top;
    logic [95:0] pc, ps;
    logic swap;
    p = longint'(t) << (PHASE_BITS - 1 - LOG_MAX + 1);
    quad = (p >> (PHASE_BITS - 2)) & 3;
    r = p & ((longint'(1) << (PHASE_BITS - 2)) - 1);
    swap = r > (longint'(1) << (PHASE_BITS - 3));
    if (swap) r = (longint'(1) << (PHASE_BITS - 2)) - r;
    x = (r * TWO_PI_Q30 + (longint'(1) << (PHASE_BITS - 1))) >> PHASE_BITS;
    x2 = (x * x) >> 30;
    ct = longint'(1) << 30;
    st = x;
    cs = ct;
    ss = st;
    for (int n = 1; n <= 6; n++) begin
      pc = 96'((ct * x2) >> 30) * 96'(RCP_COS[n - 1]);
      ps = 96'((st * x2) >> 30) * 96'(RCP_SIN[n - 1]);
      ct = 64'(pc >> RCP_SH);
      st = 64'(ps >> RCP_SH);
      if ((n & 1) == 1) begin
        cs = cs - ct;
        ss = ss - st;
      end else begin
        cs = cs + ct;
        ss = ss + st;
      end
    end
    c = swap ? longint'(ss) : longint'(cs);
    s = swap ? longint'(cs) : longint'(ss);
    unique case (quad)
      0: begin cr = c; sr = s; end
      1: begin cr = -s; sr = c; end
      2: begin cr = -c; sr = -s; end
      default: begin cr = s; sr = -c; end
    endcase
    top = (longint'(1) << (TW_BITS - 1)) - 1;
    cr = round_q(cr);
    sr = round_q(-sr);
    if (cr > top) cr = top;
    if (sr > top) sr = top;
    return {sr[TW_BITS-1:0], cr[TW_BITS-1:0]};
  endfunction

  function automatic logic [AW-1:0] bit_rev(logic [AW-1:0] v);
    logic [AW-1:0] r;
    for (int b = 0; b < AW; b++) r[AW-1-b] = v[b];
    return r;
  endfunction

  function automatic logic [LW-1:0] size_log2(logic [CW-1:0] cnt);
    logic [LW-1:0] m;
    m = LW'(1);
    for (int b = 1; b < LOG_MAX; b++) begin
      if ((CW'(1) << b) < cnt) m = LW'(b + 1);
    end
    return m;
  endfunction
endpackage

### rtl/core/fdit_mem.sv
// Work memory holding the complex data, one write port and two registered read ports.
`timescale 1ns / 1ps
module fdit_mem
  import fdit_pkg::*;
(
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [2*DATA_BITS-1:0] wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr_a,
  input  logic [AW-1:0]          raddr_b,
  output logic [2*DATA_BITS-1:0] rdata_a_r,
  output logic [2*DATA_BITS-1:0] rdata_b_r
);
  logic [2*DATA_BITS-1:0] mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end
endmodule

### rtl/core/fdit_twiddle.sv
// Twiddle factor table with a registered read.
`timescale 1ns / 1ps
module fdit_twiddle
  import fdit_pkg::*;
(
  input  logic          clk,
  input  logic          en,
  input  logic [TA-1:0] idx,
  output tw_t           wr_r,
  output tw_t           wi_r
);
  logic [2*TW_BITS-1:0] tab [TW_DEPTH];

  for (genvar g = 0; g < TW_DEPTH; g++) begin : g_tab
    assign tab[g] = tw_calc(g);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wr_r <= tab[idx][TW_BITS-1:0];
      wi_r <= tab[idx][2*TW_BITS-1:TW_BITS];
    end
  end
endmodule

### rtl/core/fdit_bfly.sv
// Butterfly datapath: registered products, then rounding and the sum and difference.
`timescale 1ns / 1ps
module fdit_bfly
  import fdit_pkg::*;
(
  input  logic  clk,
  input  logic  en_mul,
  input  logic  en_sum,
  input  data_t ar,
  input  data_t ai,
  input  data_t br,
  input  data_t bi,
  input  tw_t   wr,
  input  tw_t   wi,
  output data_t xpr_r,
  output data_t xpi_r,
  output data_t xqr_r,
  output data_t xqi_r
);
  logic signed [PROD_BITS-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [PROD_BITS:0]   sum_r, sum_i;
  data_t                       tr, ti;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      p_rr_r <= PROD_BITS'(br * wr);
      p_ii_r <= PROD_BITS'(bi * wi);
      p_ri_r <= PROD_BITS'(br * wi);
      p_ir_r <= PROD_BITS'(bi * wr);
    end
  end

  always_comb begin
    sum_r = (PROD_BITS+1)'(p_rr_r) - (PROD_BITS+1)'(p_ii_r)
            + ((PROD_BITS+1)'(1) << (TW_BITS - 2));
    sum_i = (PROD_BITS+1)'(p_ri_r) + (PROD_BITS+1)'(p_ir_r)
            + ((PROD_BITS+1)'(1) << (TW_BITS - 2));
    tr = sum_r[TW_BITS-1 +: DATA_BITS];
    ti = sum_i[TW_BITS-1 +: DATA_BITS];
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      xpr_r <= ar + tr;
      xpi_r <= ai + ti;
      xqr_r <= ar - tr;
      xqi_r <= ai - ti;
    end
  end
endmodule

### rtl/core/radix2_fft_dit_top.sv
// Top level of the radix-2 decimation-in-time FFT with its sequencer.
// Use: the input channel carries two kinds of beat, chosen by in_tuser. With
// in_tuser low a beat pushes one real sample (in_tdata) into the work memory;
// in_tlast on such a beat marks the last sample and starts the transform.
// With in_tuser high a beat asks for the next bin, which leaves on the output
// channel with its index and out_tlast on the last bin of the transform.
// A bin is presented on out_tvalid after its read beat is accepted, through the
// registered memory read port and then the output register, so a new read is
// not taken while an earlier one is still on its way out.
// The transform is run by one shared butterfly over the single work memory:
// zero padding writes zeros to entries count to N - 1, bit-reversed reordering
// reads each pair to be swapped and writes both entries back crossed, and each
// of the log2(N) passes runs each butterfly through the memory reads, products,
// sums and two write-backs. in_tready stays low for the whole transform.
// After reset a clearing pass writes zeros to all 1024 memory entries, one a
// cycle, while in_tready stays low.
// A bin waits in the output register while out_tready is low; pushes are still
// taken then, but no further read is taken until the waiting bin has left.
`timescale 1ns / 1ps
module radix2_fft_dit_top
  import fdit_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // [15:0] sample_value
  input  logic        in_tlast,
  input  logic        in_tuser,  // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // [26:0] bin_real, [53:27] bin_imag, [63:54] bin_index
  output logic        out_tlast
);
  fdit_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, count_r, count_nxt, rptr_r, rptr_nxt, n_pts, idx;
  logic [LW-1:0] m_r, m_nxt, layer_r, layer_nxt;
  logic rd_pend_r, rd_pend_nxt, out_valid_r, out_valid_nxt;
  logic rd_last_r, rd_last_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  data_t out_re_r, out_im_r;
  logic [AW-1:0] out_idx_r;
  logic out_last_r;
  logic acc, acc_push, acc_read, last;
  logic [AW-1:0] rev_i, hm, bj, bp, bq, tw_full;
  logic we, re;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [2*DATA_BITS-1:0] wdata, rdata_a, rdata_b;
  logic [TA-1:0] tw_idx;
  tw_t wr, wi;
  data_t xpr, xpi, xqr, xqi, sext;

  assign in_tready = (state_r == ST_IDLE) && !rd_pend_r && (!out_valid_r || !in_tuser);
  assign acc = in_tvalid && in_tready;
  assign acc_push = acc && !in_tuser;
  assign acc_read = acc && in_tuser;
  assign n_pts = CW'(1) << m_r;
  assign idx = (rptr_r >= n_pts) ? '0 : rptr_r;
  assign last = (idx == n_pts - CW'(1));
  assign sext = DATA_BITS'(signed'(in_tdata[SAMPLE_BITS-1:0]));
  assign rev_i = bit_rev(cnt_r[AW-1:0]) >> (LW'(AW) - m_r);
  assign hm = (AW'(1) << (layer_r - LW'(1))) - AW'(1);
  assign bj = cnt_r[AW-1:0];
  assign bp = ((bj & ~hm) << 1) | (bj & hm);
  assign bq = bp | (hm + AW'(1));
  assign tw_full = (bj & hm) << (LW'(LOG_MAX) - layer_r);
  assign tw_idx = tw_full[TA-1:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    count_nxt = count_r;
    m_nxt = m_r;
    layer_nxt = layer_r;
    rptr_nxt = rptr_r;
    rd_pend_nxt = acc_read;
    rd_idx_nxt = rd_idx_r;
    rd_last_nxt = rd_last_r;
    unique case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(MAX_POINTS - 1)) begin
          state_nxt = ST_IDLE;
          cnt_nxt = '0;
        end
      end
      ST_IDLE: begin
        if (acc_read) begin
          rd_idx_nxt = idx[AW-1:0];
          rd_last_nxt = last;
          rptr_nxt = last ? '0 : idx + CW'(1);
        end
        if (acc_push) begin
          if (count_r < CW'(MAX_POINTS)) count_nxt = count_r + CW'(1);
          if (in_tlast) begin
            state_nxt = ST_PAD;
            m_nxt = size_log2(count_nxt);
            cnt_nxt = count_nxt;
          end
        end
      end
      ST_PAD: begin
        if (cnt_r < n_pts) begin
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          state_nxt = ST_REV_RD;
          cnt_nxt = '0;
        end
      end
      ST_REV_RD: begin
        if (cnt_r == n_pts) begin
          state_nxt = ST_BF_RD;
          cnt_nxt = '0;
          layer_nxt = LW'(1);
        end else if (cnt_r[AW-1:0] < rev_i) begin
          state_nxt = ST_REV_W1;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_REV_W1: state_nxt = ST_REV_W2;
      ST_REV_W2: begin
        state_nxt = ST_REV_RD;
        cnt_nxt = cnt_r + CW'(1);
      end
      ST_BF_RD: begin
        if (cnt_r == (n_pts >> 1)) begin
          cnt_nxt = '0;
          if (layer_r == m_r) begin
            state_nxt = ST_IDLE;
            count_nxt = '0;
            rptr_nxt = '0;
          end else begin
            layer_nxt = layer_r + LW'(1);
          end
        end else begin
          state_nxt = ST_BF_MUL;
        end
      end
      ST_BF_MUL: state_nxt = ST_BF_SUM;
      ST_BF_SUM: state_nxt = ST_BF_WP;
      ST_BF_WP:  state_nxt = ST_BF_WQ;
      ST_BF_WQ: begin
        state_nxt = ST_BF_RD;
        cnt_nxt = cnt_r + CW'(1);
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = cnt_r[AW-1:0];
    wdata = '0;
    re = 1'b0;
    raddr_a = idx[AW-1:0];
    raddr_b = rev_i;
    unique case (state_r)
      ST_CLEAR: we = 1'b1;
      ST_IDLE: begin
        re = acc_read;
        waddr = count_r[AW-1:0];
        wdata = {DATA_BITS'(0), sext};
        we = acc_push && (count_r < CW'(MAX_POINTS));
      end
      ST_PAD: we = (cnt_r < n_pts);
      ST_REV_RD: begin
        raddr_a = cnt_r[AW-1:0];
        re = (cnt_r != n_pts) && (cnt_r[AW-1:0] < rev_i);
      end
      ST_REV_W1: begin
        we = 1'b1;
        wdata = rdata_b;
      end
      ST_REV_W2: begin
        we = 1'b1;
        waddr = rev_i;
        wdata = rdata_a;
      end
      ST_BF_RD: begin
        raddr_a = bp;
        raddr_b = bq;
        re = (cnt_r != (n_pts >> 1));
      end
      ST_BF_WP: begin
        we = 1'b1;
        waddr = bp;
        wdata = {xpi, xpr};
      end
      ST_BF_WQ: begin
        we = 1'b1;
        waddr = bq;
        wdata = {xqi, xqr};
      end
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (rd_pend_r) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r <= '0;
      count_r <= '0;
      m_r <= LW'(1);
      layer_r <= LW'(1);
      rptr_r <= '0;
      rd_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      count_r <= count_nxt;
      m_r <= m_nxt;
      layer_r <= layer_nxt;
      rptr_r <= rptr_nxt;
      rd_pend_r <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    rd_last_r <= rd_last_nxt;
    if (rd_pend_r) begin
      out_re_r <= rdata_a[DATA_BITS-1:0];
      out_im_r <= rdata_a[2*DATA_BITS-1:DATA_BITS];
      out_idx_r <= rd_idx_r;
      out_last_r <= rd_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {10'(out_idx_r), out_im_r, out_re_r};
  assign out_tlast = out_last_r;

  fdit_mem u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .re(re),
    .raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a_r(rdata_a), .rdata_b_r(rdata_b)
  );

  fdit_twiddle u_tw (
    .clk(clk), .en(state_r == ST_BF_RD), .idx(tw_idx), .wr_r(wr), .wi_r(wi)
  );

  fdit_bfly u_bfly (
    .clk(clk), .en_mul(state_r == ST_BF_MUL), .en_sum(state_r == ST_BF_SUM),
    .ar(rdata_a[DATA_BITS-1:0]), .ai(rdata_a[2*DATA_BITS-1:DATA_BITS]),
    .br(rdata_b[DATA_BITS-1:0]), .bi(rdata_b[2*DATA_BITS-1:DATA_BITS]),
    .wr(wr), .wi(wi), .xpr_r(xpr), .xpi_r(xpi), .xqr_r(xqr), .xqi_r(xqi)
  );
endmodule

### rtl/core/fdit_checker.sv
// Port-level checker for the FFT top level and its bind statement.
`timescale 1ns / 1ps
module fdit_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast
);
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Output beat valid straight after reset.");
  a_clear_busy: assert property (@(posedge clk) (rst_n && $past(!rst_n)) |-> !in_tready)
    else $error("Input taken during the clearing pass.");
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[63:54] != 10'd0))
    else $error("Last bin carries index zero.");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("Stalled output beat changed.");
endmodule

bind radix2_fft_dit_top fdit_checker u_fdit_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tlast(out_tlast)
);

### verif/radix2_fft_dit_top_tb.sv
// Self-checking testbench for the radix-2 DIT FFT top level with its own bin predictor.
`timescale 1ns / 1ps
module radix2_fft_dit_top_tb;
  import fdit_pkg::*;

  typedef struct {
    logic        op;
    logic [15:0] smp;
    logic        fin;
    bit          hold;
  } beat_t;

  typedef struct {
    logic [26:0] re;
    logic [26:0] im;
    logic [9:0]  idx;
    logic        fin;
  } bin_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;

  beat_t  pending[$];
  bin_t   bins_due[$];
  beat_t  cur;
  bit     taken = 0;
  int     errors = 0;
  int     gap_left = 0;
  int     burst_left = 8;
  int     stall_mode = 0;
  int     stall_len = 0;

  longint acc_re[MAX_POINTS];
  longint acc_im[MAX_POINTS];
  longint cos_q[MAX_POINTS/2];
  longint sin_q[MAX_POINTS/2];
  int     loaded;
  int     fft_log2;
  int     bin_ptr;

  radix2_fft_dit_top dut (.*);

  always #10 clk = ~clk;

  function automatic longint q15_round(longint v);
    return (v + (longint'(1) << 14)) >>> 15;
  endfunction

  function automatic void build_twiddles();
    longint unsigned ph, quad, r, x, x2, ct, st, cs, ss;
    longint c, s, cr, sr;
    bit swap;
    for (int j = 0; j < MAX_POINTS / 2; j++) begin
      ph = longint'(j) << 6;
      quad = (ph >> 14) & 3;
      r = ph & 16383;
      swap = r > 8192;
      if (swap) r = 16384 - r;
      x = (r * TWO_PI_Q30 + 32768) >> 16;
      x2 = (x * x) >> 30;
      ct = longint'(1) << 30;
      st = x;
      cs = ct;
      ss = st;
      for (int n = 1; n <= 6; n++) begin
        ct = ((ct * x2) >> 30) / ((2 * n - 1) * (2 * n));
        st = ((st * x2) >> 30) / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          cs -= ct;
          ss -= st;
        end else begin
          cs += ct;
          ss += st;
        end
      end
      c = swap ? longint'(ss) : longint'(cs);
      s = swap ? longint'(cs) : longint'(ss);
      case (quad)
        0: begin cr = c; sr = s; end
        1: begin cr = -s; sr = c; end
        2: begin cr = -c; sr = -s; end
        default: begin cr = s; sr = -c; end
      endcase
      cr = q15_round(cr);
      sr = q15_round(-sr);
      cos_q[j] = cr > 32767 ? 32767 : cr;
      sin_q[j] = sr > 32767 ? 32767 : sr;
    end
  endfunction

  function automatic int frame_log2(int cnt);
    int m;
    m = 1;
    while (m < LOG_MAX && (1 << m) < cnt) m++;
    return m;
  endfunction

  function automatic void transform_frame();
    int m, n, r, half, p, q, t;
    longint tmp, tr, ti;
    m = frame_log2(loaded);
    n = 1 << m;
    for (int i = loaded; i < n; i++) begin
      acc_re[i] = 0;
      acc_im[i] = 0;
    end
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int b = 0; b < m; b++) r |= ((i >> b) & 1) << (m - 1 - b);
      if (i < r) begin
        tmp = acc_re[i]; acc_re[i] = acc_re[r]; acc_re[r] = tmp;
        tmp = acc_im[i]; acc_im[i] = acc_im[r]; acc_im[r] = tmp;
      end
    end
    for (int s = 1; s <= m; s++) begin
      half = 1 << (s - 1);
      for (int g = 0; g < n; g += 2 * half) begin
        for (int k = 0; k < half; k++) begin
          p = g + k;
          q = p + half;
          t = k << (LOG_MAX - s);
          tr = q15_round(acc_re[q] * cos_q[t] - acc_im[q] * sin_q[t]);
          ti = q15_round(acc_re[q] * sin_q[t] + acc_im[q] * cos_q[t]);
          acc_re[q] = acc_re[p] - tr;
          acc_im[q] = acc_im[p] - ti;
          acc_re[p] = acc_re[p] + tr;
          acc_im[p] = acc_im[p] + ti;
        end
      end
    end
    fft_log2 = m;
    loaded = 0;
    bin_ptr = 0;
  endfunction

  function automatic void predict_beat(beat_t b);
    bin_t e;
    int n, idx;
    if (b.op == OP_PUSH) begin
      if (loaded < MAX_POINTS) begin
        acc_re[loaded] = longint'(signed'(b.smp));
        acc_im[loaded] = 0;
        loaded++;
      end
      if (b.fin) transform_frame();
    end else begin
      n = 1 << fft_log2;
      idx = bin_ptr >= n ? 0 : bin_ptr;
      e.re = acc_re[idx][26:0];
      e.im = acc_im[idx][26:0];
      e.idx = idx[9:0];
      e.fin = (idx == n - 1);
      bins_due = {bins_due, e};
      bin_ptr = e.fin ? 0 : idx + 1;
    end
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void add_push(logic [15:0] v, logic f);
    beat_t b;
    b.op = OP_PUSH;
    b.smp = v;
    b.fin = f;
    b.hold = 0;
    pending = {pending, b};
  endfunction

  function automatic void add_reads(int cnt);
    beat_t b;
    for (int i = 0; i < cnt; i++) begin
      b.op = OP_READ;
      b.smp = 16'($urandom);
      b.fin = 1'($urandom);
      b.hold = 0;
      pending = {pending, b};
    end
  endfunction

  function automatic void add_frame(int cnt, int reads);
    for (int i = 0; i < cnt; i++) add_push(pick_sample(), i == cnt - 1);
    add_reads(reads);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_beat(cur);
      taken = 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (bins_due.size() == 0) begin
        $error("unexpected bin beat, index %0d", out_tdata[63:54]);
        errors++;
      end else begin
        bin_t e;
        e = bins_due.pop_front();
        if (out_tdata[26:0] !== e.re) begin
          $error("bin_real: expected %0d, got %0d", $signed(e.re), $signed(out_tdata[26:0]));
          errors++;
        end
        if (out_tdata[53:27] !== e.im) begin
          $error("bin_imag: expected %0d, got %0d", $signed(e.im), $signed(out_tdata[53:27]));
          errors++;
        end
        if (out_tdata[63:54] !== e.idx) begin
          $error("bin_index: expected %0d, got %0d", e.idx, out_tdata[63:54]);
          errors++;
        end
        if (out_tlast !== e.fin) begin
          $error("final_bin: expected %0b, got %0b", e.fin, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    logic v;
    v = 1'b0;
    if (rst_n) begin
      if (in_tvalid && !taken) begin
        v = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending.size() != 0 && !(pending[0].hold && bins_due.size() != 0)) begin
        cur = pending.pop_front();
        v = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    taken = 0;
    in_tvalid <= v;
    in_tdata <= cur.smp;
    in_tlast <= cur.fin;
    in_tuser <= cur.op;
    if (stall_len <= 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_len = $urandom_range(10, 80);
    end
    stall_len--;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= 1'b1 ^ ($urandom_range(0, 1) == 0);
    endcase
  end

  initial begin
    int total, cnt, n;
    bit big_done;
    beat_t b;
    cur = '{OP_PUSH, 16'h0000, 1'b0, 0};
    loaded = 0;
    fft_log2 = 1;
    bin_ptr = 0;
    big_done = 1'b0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      acc_re[i] = 0;
      acc_im[i] = 0;
    end
    build_twiddles();

    // Reads straight after reset see the cleared memory and wrap after two bins.
    add_reads(3);
    add_push(16'h8000, 1'b1);
    add_reads(2);
    add_push(16'h7fff, 1'b0);
    add_push(16'h8000, 1'b0);
    // A read while loading returns the raw samples.
    add_reads(2);
    add_push(16'h7fff, 1'b1);
    add_reads(5);
    add_frame(4, 4);
    total = 24;

    while (total < 1200) begin
      if ($urandom_range(0, 9) == 0) begin
        cnt = 1 << $urandom_range(1, 6);
      end else begin
        cnt = $urandom_range(1, 40);
      end
      n = 1 << frame_log2(cnt);
      case ($urandom_range(0, 7))
        0: add_frame(cnt, $urandom_range(0, n + 3));
        1: begin
          add_reads($urandom_range(0, 3));
          add_frame(cnt, n);
        end
        default: add_frame(cnt, n);
      endcase
      total += cnt + n;
      if (!big_done && total > 100) begin
        big_done = 1'b1;
        b = '{OP_READ, 16'h1234, 1'b0, 1};
        pending = {pending, b};
        // A full-size frame with extra samples that overflow the memory.
        add_frame(MAX_POINTS + 3, 48);
        total += MAX_POINTS + 3 + 48 + 1;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (pending.size() != 0 || in_tvalid || bins_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && bins_due.size() == 0) begin
      $display("[radix2_fft_dit_top] OK");
    end else begin
      $display("[radix2_fft_dit_top] ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("[radix2_fft_dit_top] ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/core/fdit_pkg.sv
rtl/core/fdit_mem.sv
rtl/core/fdit_twiddle.sv
rtl/core/fdit_bfly.sv
rtl/core/radix2_fft_dit_top.sv
rtl/core/fdit_checker.sv
verif/radix2_fft_dit_top_tb.sv
